// ===== sv/ordered_list_push_pop_insert_before_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_PUSH_POP_INSERT_BEFORE_CORE_DEFINES_SVH
`define ORDERED_LIST_PUSH_POP_INSERT_BEFORE_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define OLPIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define OLPIB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/olpib_pkg.sv =====
// ----------------------------------------------------------------------------
// olpib_pkg
// Shared types and codes for the ordered list core and its cells.
// ----------------------------------------------------------------------------
package olpib_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Value returned by a pop on an empty list.
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd999;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] anchor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped;
  } out_item_t;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] anchor;
  } cell_ctrl_t;

endpackage

// ===== sv/ordered_list_push_pop_insert_before_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_push_pop_insert_before_core
// Bounded ordered list of signed 32-bit values with push-front,
// insert-before-anchor and pop-front, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the command transfer happens at a rising
//   edge with start high and busy low. busy is always low: a command may be
//   given in every cycle.
//   Exactly one result per command appears on out_item in the following
//   cycle, marked by out_valid for that single cycle.
//   Throughput is one command per cycle, which the cell row allows: every
//   cell compares its entry with the anchor and the hit chain runs through
//   all DEPTH cells, then all cells shift at the same edge.
//   Status codes: ok, empty (pop on an empty list, popped carries -999),
//   anchor not found, full (push or insert with DEPTH entries held).
//   Reset empties the list (fill count zero) and clears out_valid; entry
//   contents are not reset. The receiver cannot stall: a result is
//   transferred in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "ordered_list_push_pop_insert_before_core_defines.svh"

module ordered_list_push_pop_insert_before_core #(
  parameter int DEPTH = olpib_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  olpib_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output olpib_pkg::out_item_t  out_item
);
  import olpib_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         result;
  cell_ctrl_t        cell_ctrl;
  logic              accept;
  logic              full;
  logic              empty;
  logic              found;
  logic [DEPTH:0]    chain_hit;
  logic [DEPTH-1:0]  occupied;
  logic [DATA_W-1:0] cell_data [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // A push is an insertion ahead of the head: the hit chain starts set.
  assign chain_hit[0] = (in_item.kind == KIND_PUSH);
  assign found        = chain_hit[DEPTH];

  // Row of cells; each one sees its neighbours' entries.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    assign occupied[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_d = in_item.value;
    end else begin : g_body
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    olpib_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .occupied   (occupied[i]),
      .new_data   (in_item.value),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_in     (chain_hit[i]),
      .hit_out    (chain_hit[i+1]),
      .data       (cell_data[i])
    );
  end

  // Command decode: cell operation, fill count and result.
  always_comb begin
    cell_ctrl.op     = CELL_HOLD;
    cell_ctrl.anchor = in_item.anchor;
    count_nxt        = count_r;
    result.status    = ST_OK;
    result.popped    = '0;
    if (accept) begin
      unique case (in_item.kind)
        KIND_PUSH: begin
          if (full) begin
            result.status = ST_FULL;
          end else begin
            cell_ctrl.op = CELL_INSERT;
            count_nxt    = count_r + CNT_W'(1);
          end
        end
        KIND_INSERT: begin
          if (full) begin
            result.status = ST_FULL;
          end else if (found) begin
            cell_ctrl.op = CELL_INSERT;
            count_nxt    = count_r + CNT_W'(1);
          end else begin
            result.status = ST_NOT_FOUND;
          end
        end
        KIND_POP: begin
          if (empty) begin
            result.status = ST_EMPTY;
            result.popped = EMPTY_MARK;
          end else begin
            cell_ctrl.op  = CELL_POP;
            count_nxt     = count_r - CNT_W'(1);
            result.popped = cell_data[0];
          end
        end
        default: begin
          result.status = ST_OK;
        end
      endcase
    end
  end

  // Fill count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks on the core's own bookkeeping.
  `OLPIB_ASSERT_NEXT(a_one_result, clk, rst_n, accept, out_valid, "command without result")
  `OLPIB_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "fill count overflow")
  `OLPIB_ASSERT_NEXT(a_pop_empty, clk, rst_n, accept && in_item.kind == KIND_POP && empty, out_item.status == ST_EMPTY && out_item.popped == EMPTY_MARK, "empty pop misreported")
  `OLPIB_ASSERT_NEXT(a_push_grows, clk, rst_n, accept && in_item.kind == KIND_PUSH && !full, count_r == $past(count_r) + CNT_W'(1), "push did not grow list")

endmodule

// ===== sv/olpib_cell.sv =====
// ----------------------------------------------------------------------------
// olpib_cell
// One list position: holds an entry, compares it with the anchor and takes
// its neighbour's entry when the list shifts.
// ----------------------------------------------------------------------------
module olpib_cell (
  input  logic                                clk,
  input  olpib_pkg::cell_ctrl_t               ctrl,
  input  logic                                occupied,
  input  logic [olpib_pkg::DATA_W-1:0]        new_data,
  input  logic [olpib_pkg::DATA_W-1:0]        left_data,
  input  logic [olpib_pkg::DATA_W-1:0]        right_data,
  input  logic                                hit_in,
  output logic                                hit_out,
  output logic [olpib_pkg::DATA_W-1:0]        data
);
  import olpib_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              match;

  // A match counts only on an occupied position.
  assign match   = occupied && (data_r == ctrl.anchor);
  assign hit_out = hit_in || match;
  assign data    = data_r;

  // Behind the insertion point the entries move one place towards the tail;
  // the first matching cell takes the new value. On a push the head cell
  // sees the new value on its left input, so it shifts it in like the rest.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (hit_in) begin
          data_nxt = left_data;
        end else if (match) begin
          data_nxt = new_data;
        end
      end
      CELL_POP: begin
        data_nxt = right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry storage; no reset, occupancy is tracked by the fill count.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== test/tb_ordered_list_push_pop_insert_before_core.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_list_push_pop_insert_before_core
// Self-checking bench for the ordered list core. A short scripted sequence
// covers empty, full, not-found and head/tail insertion. Biased random
// command runs follow, with the sender idling at several rates. Every result
// is checked against the bench's own shadow list or a hand-written value.
// ----------------------------------------------------------------------------
module tb_ordered_list_push_pop_insert_before_core;
  import olpib_pkg::*;

  localparam int          LIST_DEPTH      = DEPTH_DEF;
  localparam int          ITEMS_PER_PHASE = 488;
  localparam int          N_ROWS          = 20;
  localparam int          REPORT_LIMIT    = 50;
  // The kind field can carry one code that the core treats as a no-op.
  localparam logic [1:0]  KIND_NOP        = 2'd3;

  // One line of the scripted sequence: the command, how many times it is
  // issued, and a hand-written result where one is given.
  typedef struct packed {
    in_item_t  cmd;
    logic [4:0] reps;
    logic       fixed;
    out_item_t  result;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  // Hand-written result travelling alongside a scripted command.
  logic      fixed_on = 1'b0;
  out_item_t fixed_want = '0;

  // Shadow of the list contents, head at index 0.
  logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
  int unsigned              shadow_len = 0;

  out_item_t awaited_results [$];
  out_item_t want_res;
  int        mismatch_count = 0;

  row_t script [N_ROWS] = '{
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd1,  1'b1, '{ST_EMPTY, EMPTY_MARK}},
    '{'{KIND_INSERT, 32'sd1,           32'sd0          }, 5'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0}},
    '{'{KIND_NOP,    -32'sd1,          -32'sd1         }, 5'd1,  1'b1, '{ST_OK, 32'sd0}},
    '{'{KIND_PUSH,   32'sh7fffffff,    32'sd0          }, 5'd1,  1'b1, '{ST_OK, 32'sd0}},
    '{'{KIND_PUSH,   32'sh80000000,    32'sd0          }, 5'd1,  1'b1, '{ST_OK, 32'sd0}},
    '{'{KIND_INSERT, -32'sd1,          32'sh7fffffff   }, 5'd1,  1'b0, '0},
    '{'{KIND_INSERT, 32'sd5,           32'sd12345      }, 5'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0}},
    '{'{KIND_INSERT, 32'sd42,          32'sh80000000   }, 5'd1,  1'b0, '0},
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd2,  1'b0, '0},
    '{'{KIND_PUSH,   32'sd0,           32'sd0          }, 5'd13, 1'b0, '0},
    '{'{KIND_INSERT, 32'sd9,           32'sd0          }, 5'd1,  1'b0, '0},
    '{'{KIND_PUSH,   32'sd1,           32'sd0          }, 5'd1,  1'b1, '{ST_FULL, 32'sd0}},
    '{'{KIND_INSERT, 32'sd2,           -32'sd1         }, 5'd1,  1'b1, '{ST_FULL, 32'sd0}},
    '{'{KIND_INSERT, 32'sd3,           32'sd12345      }, 5'd1,  1'b1, '{ST_FULL, 32'sd0}},
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd16, 1'b0, '0},
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd1,  1'b1, '{ST_EMPTY, EMPTY_MARK}},
    '{'{KIND_INSERT, 32'sd7,           32'sd0          }, 5'd1,  1'b1, '{ST_NOT_FOUND, 32'sd0}},
    '{'{KIND_PUSH,   -32'sd999,        32'sd0          }, 5'd1,  1'b1, '{ST_OK, 32'sd0}},
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd1,  1'b0, '0},
    '{'{KIND_POP,    32'sd0,           32'sd0          }, 5'd1,  1'b1, '{ST_EMPTY, EMPTY_MARK}}
  };

  ordered_list_push_pop_insert_before_core #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Prints one mismatch line, up to a limit, and counts every mismatch.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Applies one command to the shadow list and returns the result it gives.
  function automatic out_item_t apply_command(input in_item_t cmd);
    out_item_t   res;
    int unsigned pos;
    bit          hit;
    res = '{ST_OK, '0};
    pos = 0;
    case (cmd.kind)
      KIND_PUSH, KIND_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          // The full check comes before any anchor search.
          res.status = ST_FULL;
        end else begin
          hit = (cmd.kind == KIND_PUSH);
          for (int unsigned i = 0; i < shadow_len && !hit; i++) begin
            if (shadow_list[i] == cmd.anchor) begin
              pos = i;
              hit = 1'b1;
            end
          end
          if (hit) begin
            for (int unsigned i = shadow_len; i > pos; i--) begin
              shadow_list[i] = shadow_list[i-1];
            end
            shadow_list[pos] = cmd.value;
            shadow_len++;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
      end
      KIND_POP: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
          res.popped = EMPTY_MARK;
        end else begin
          res.popped = shadow_list[0];
          for (int unsigned i = 1; i < shadow_len; i++) begin
            shadow_list[i-1] = shadow_list[i];
          end
          shadow_len--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random word leaning towards the extremes and a small pool of values, so
  // that duplicates and anchor hits are common.
  function automatic logic signed [DATA_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case (pick % 4)
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end else if (pick < 45) begin
      return $signed($urandom_range(6)) - 3;
    end
    return $urandom;
  endfunction

  // Issues one command, entered and left at a falling edge. The sender may
  // stay idle for a random number of cycles first.
  task automatic send_cmd(input in_item_t cmd, input int idle_pct,
                          input logic fixed, input out_item_t result);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_item    <= cmd;
    fixed_on   <= fixed;
    fixed_want <= result;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Holds the sender back until every awaited result has come.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  // Result check and prediction, both at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d popped %0d",
                                    out_item.status, out_item.popped));
        end else begin
          want_res = awaited_results.pop_front();
          if (out_item.status !== want_res.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item.status, want_res.status));
          end
          if (out_item.popped !== want_res.popped) begin
            report_mismatch($sformatf("popped %0d, expected %0d",
                                      out_item.popped, want_res.popped));
          end
        end
      end
      if (start && !busy) begin
        want_res = apply_command(in_item);
        if (fixed_on) begin
          want_res = fixed_want;
        end
        awaited_results.push_back(want_res);
      end
    end
  end

  // Stimulus: reset, the scripted sequence, then random phases.
  initial begin : stimulus
    in_item_t    cmd;
    int          idle_pct;
    int unsigned grow_pct;
    int unsigned pick;
    int          wait_cycles;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        send_cmd(script[r].cmd, 0, script[r].fixed, script[r].result);
      end
    end

    // Each phase begins with the pipeline drained; the sender's idle rate
    // changes from phase to phase.
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      idle_pct = (ph == 1) ? 83 : (ph == 2) ? 35 : 0;
      grow_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Runs that favour growth or shrinkage drive the list to full and
        // back to empty again and again.
        if (n % 40 == 0) begin
          pick     = $urandom_range(2);
          grow_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 85;
        end
        pick       = $urandom_range(99);
        cmd.value  = rand_word();
        cmd.anchor = rand_word();
        if (pick < 2) begin
          cmd.kind = KIND_NOP;
        end else if (pick < 2 + grow_pct) begin
          cmd.kind = ($urandom_range(99) < 40) ? KIND_PUSH : KIND_INSERT;
          // Mostly aim at an entry that is held, so that inserts land.
          if (shadow_len != 0 && $urandom_range(99) < 75) begin
            cmd.anchor = shadow_list[$urandom_range(shadow_len - 1)];
          end
        end else begin
          cmd.kind = KIND_POP;
        end
        send_cmd(cmd, idle_pct, 1'b0, '0);
      end
    end

    // Let the last results come out, with a bound.
    start <= 1'b0;
    wait_cycles = 0;
    while (awaited_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never came", awaited_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
